// File: hw/rtl/tpdc_pkg.sv
// Shared types and constants for the touch pressure / calibration block.
// Used by tpdc_div and touch_pressure_detect_calibrate; depends on nothing.
package tpdc_pkg;

    // Shared divider geometry: 44-bit dividend magnitude, 32-bit divisor magnitude
    localparam int DVD_W = 44;
    localparam int DSR_W = 32;
    localparam int CNT_W = 6;

    // Pressure division: 20-bit product placed at the top of the dividend
    localparam int PRESS_W = 20;
    localparam int PRESS_SHIFT = DVD_W - PRESS_W;
    localparam logic [CNT_W-1:0] PRESS_STEPS = CNT_W'(PRESS_W);
    localparam logic [CNT_W-1:0] CAL_STEPS = CNT_W'(DVD_W);

    localparam int LEVEL_W = 10;
    localparam int COEF_W = 32;
    localparam logic [31:0] FULL_SCALE = 32'd1024;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_COEF_A = 3'd1;
    localparam logic [2:0] REG_COEF_B = 3'd2;
    localparam logic [2:0] REG_COEF_C = 3'd3;
    localparam logic [2:0] REG_COEF_D = 3'd4;
    localparam logic [2:0] REG_COEF_E = 3'd5;
    localparam logic [2:0] REG_COEF_F = 3'd6;
    localparam logic [2:0] REG_DIVIDER = 3'd7;

    // Reset values of the configuration registers
    localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 10'd950;
    localparam logic [COEF_W-1:0] COEF_A_RST = 32'sd76320;
    localparam logic [COEF_W-1:0] COEF_B_RST = 32'sd3080;
    localparam logic [COEF_W-1:0] COEF_C_RST = -32'sd9475080;
    localparam logic [COEF_W-1:0] COEF_D_RST = -32'sd560;
    localparam logic [COEF_W-1:0] COEF_E_RST = 32'sd60340;
    localparam logic [COEF_W-1:0] COEF_F_RST = -32'sd4360660;
    localparam logic [COEF_W-1:0] DIVIDER_RST = 32'sd205664;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } tpdc_div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
    } tpdc_div_rsp_t;

endpackage

// File: hw/rtl/tpdc_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on tpdc_pkg for widths and the request/response structs.
module tpdc_div
    import tpdc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  tpdc_div_req_t req,
    output tpdc_div_rsp_t rsp
);

    logic [DVD_W-1:0] dq_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DSR_W:0]   shifted;
    logic [DSR_W:0]   trial;

    // Remainder stays below the divisor, so the shifted value fits in DSR_W+1 bits
    assign shifted = {rem_reg, dq_reg[DVD_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                dq_reg    <= req.dividend;
                dsr_reg   <= req.divisor;
                rem_reg   <= '0;
                count_reg <= req.steps;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                if (!trial[DSR_W]) begin
                    rem_reg <= trial[DSR_W-1:0];
                    dq_reg  <= {dq_reg[DVD_W-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[DSR_W-1:0];
                    dq_reg  <= {dq_reg[DVD_W-2:0], 1'b0};
                end
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dq_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_ends_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a run");

    a_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> count_reg != '0)
        else $error("divider busy with zero count");

endmodule

// File: hw/rtl/touch_pressure_detect_calibrate.sv
// Touch pressure detection and affine calibration, top level; uses tpdc_pkg and tpdc_div.
// Each accepted scan runs a 20-step pressure division and a touch check. A release, or a press
// with a zero divider, then gives a result; a calibrated press first runs two 44-step divisions.
// A scan with neither press nor release gives no result. A new scan is taken only in idle;
// a result not yet taken (m_tready low) stalls the sequencer in its output state.
// Reset (aresetn, synchronous): pen up, stored point and time cleared, registers to defaults.
module touch_pressure_detect_calibrate
    import tpdc_pkg::*;
#(
    parameter int DEBOUNCE_TICKS = 100,
    parameter int SWAP_AXES = 0
)
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input scan beat
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // z1_level, z2_level, x_level, y_level, now_ticks
    // Result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // pen_down
    output logic [87:0] m_tdata,   // raw_x, raw_y, cal_x, cal_y, zero pad
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_PDIV   = 4'd1;
    localparam logic [3:0] ST_PCHK   = 4'd2;
    localparam logic [3:0] ST_MUL1   = 4'd3;
    localparam logic [3:0] ST_MUL2   = 4'd4;
    localparam logic [3:0] ST_ADD    = 4'd5;
    localparam logic [3:0] ST_DSTART = 4'd6;
    localparam logic [3:0] ST_CDIV   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    localparam int ACC_W = DVD_W;
    localparam int PROD_W = COEF_W + LEVEL_W + 1;

    // Configuration registers
    logic [LEVEL_W-1:0] thr_reg;
    logic [COEF_W-1:0]  coef_a_reg, coef_b_reg, coef_c_reg;
    logic [COEF_W-1:0]  coef_d_reg, coef_e_reg, coef_f_reg;
    logic [COEF_W-1:0]  divider_reg;

    // Sequencer and scan latch
    logic [3:0]         state_reg, state_next;
    logic               phase_reg;          // 0: display x, 1: display y
    logic [LEVEL_W-1:0] x_reg, y_reg;
    logic [31:0]        now_reg;

    // Persistent touch state
    logic               touch_active_reg;
    logic [31:0]        press_time_reg;
    logic [LEVEL_W-1:0] last_raw_x_reg, last_raw_y_reg;
    logic [COEF_W-1:0]  last_cal_x_reg, last_cal_y_reg;

    // Calibration datapath
    logic signed [ACC_W-1:0] prod_reg, acc_reg;
    logic                    negq_reg;

    // Result register
    logic        m_tvalid_reg;
    logic        m_tuser_reg;
    logic [87:0] m_tdata_reg;

    tpdc_div_req_t div_req;
    tpdc_div_rsp_t div_rsp;

    // Input field views
    logic [LEVEL_W-1:0] z1_in, z2_in, x_in, y_in;
    logic [31:0]        now_in;
    logic [LEVEL_W-1:0] z1_eff;
    logic [PRESS_W-1:0] xz2;

    assign z1_in  = s_tdata[9:0];
    assign z2_in  = s_tdata[19:10];
    assign x_in   = s_tdata[29:20];
    assign y_in   = s_tdata[39:30];
    assign now_in = s_tdata[71:40];

    // Clamp z1 to at least one
    assign z1_eff = (z1_in == '0) ? LEVEL_W'(1) : z1_in;
    assign xz2    = x_in * z2_in;

    assign s_tready = (state_reg == ST_IDLE);

    // Pressure: rz = (x*z2/z1 - x) / 1024, p = 1024 - rz, all wrapping 32-bit
    logic [31:0] press_diff, press_rz, press_p;
    logic        is_touch;
    logic [31:0] elapsed;
    logic        is_release;

    assign press_diff = {12'b0, div_rsp.quotient[PRESS_W-1:0]} - {22'b0, x_reg};
    assign press_rz   = {10'b0, press_diff[31:10]};
    assign press_p    = FULL_SCALE - press_rz;
    assign is_touch   = press_p > {22'b0, thr_reg};
    assign elapsed    = now_reg - press_time_reg;
    assign is_release = touch_active_reg && (elapsed >= 32'(DEBOUNCE_TICKS));

    // Shared multiplier: signed coefficient times unsigned raw level
    logic [COEF_W-1:0]        mul_k;
    logic [LEVEL_W-1:0]       mul_r;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  coef_off_ext;

    always_comb begin
        if (state_reg == ST_MUL2) begin
            mul_k = phase_reg ? coef_e_reg : coef_b_reg;
            mul_r = last_raw_y_reg;
        end else begin
            mul_k = phase_reg ? coef_d_reg : coef_a_reg;
            mul_r = last_raw_x_reg;
        end
    end

    assign prod         = $signed(mul_k) * $signed({1'b0, mul_r});
    assign prod_ext     = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    assign coef_off_ext = phase_reg
                        ? {{(ACC_W-COEF_W){coef_f_reg[COEF_W-1]}}, coef_f_reg}
                        : {{(ACC_W-COEF_W){coef_c_reg[COEF_W-1]}}, coef_c_reg};

    // Magnitudes for the unsigned divider; quotient sign fixed up afterwards
    logic [ACC_W-1:0]  num_mag;
    logic [DSR_W-1:0]  div_mag;
    logic [COEF_W-1:0] cal_q;

    assign num_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
    assign div_mag = divider_reg[COEF_W-1] ? DSR_W'(-divider_reg) : divider_reg;
    assign cal_q   = negq_reg ? COEF_W'(-div_rsp.quotient[COEF_W-1:0])
                              : div_rsp.quotient[COEF_W-1:0];

    always_comb begin
        div_req.start    = 1'b0;
        div_req.steps    = PRESS_STEPS;
        div_req.dividend = {xz2, {PRESS_SHIFT{1'b0}}};
        div_req.divisor  = {{(DSR_W-LEVEL_W){1'b0}}, z1_eff};
        if (state_reg == ST_IDLE && s_tvalid) begin
            div_req.start = 1'b1;
        end else if (state_reg == ST_DSTART) begin
            div_req.start    = 1'b1;
            div_req.steps    = CAL_STEPS;
            div_req.dividend = num_mag;
            div_req.divisor  = div_mag;
        end
    end

    tpdc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_PDIV;
                end
            end
            ST_PDIV: begin
                if (div_rsp.done) begin
                    state_next = ST_PCHK;
                end
            end
            ST_PCHK: begin
                if (is_touch) begin
                    state_next = (divider_reg == '0) ? ST_OUT : ST_MUL1;
                end else if (is_release) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_ADD;
            ST_ADD:    state_next = ST_DSTART;
            ST_DSTART: state_next = ST_CDIV;
            ST_CDIV: begin
                if (div_rsp.done) begin
                    state_next = phase_reg ? ST_OUT : ST_MUL1;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Configuration writes; the host must write only between scans, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg     <= THRESHOLD_RST;
            coef_a_reg  <= COEF_A_RST;
            coef_b_reg  <= COEF_B_RST;
            coef_c_reg  <= COEF_C_RST;
            coef_d_reg  <= COEF_D_RST;
            coef_e_reg  <= COEF_E_RST;
            coef_f_reg  <= COEF_F_RST;
            divider_reg <= DIVIDER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_THRESHOLD: thr_reg     <= cfg_wdata[LEVEL_W-1:0];
                REG_COEF_A:    coef_a_reg  <= cfg_wdata;
                REG_COEF_B:    coef_b_reg  <= cfg_wdata;
                REG_COEF_C:    coef_c_reg  <= cfg_wdata;
                REG_COEF_D:    coef_d_reg  <= cfg_wdata;
                REG_COEF_E:    coef_e_reg  <= cfg_wdata;
                REG_COEF_F:    coef_f_reg  <= cfg_wdata;
                REG_DIVIDER:   divider_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer, touch state and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            phase_reg        <= 1'b0;
            touch_active_reg <= 1'b0;
            press_time_reg   <= '0;
            last_raw_x_reg   <= '0;
            last_raw_y_reg   <= '0;
            last_cal_x_reg   <= '0;
            last_cal_y_reg   <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    // Latch the scan while the pressure division starts
                    if (s_tvalid) begin
                        x_reg   <= x_in;
                        y_reg   <= y_in;
                        now_reg <= now_in;
                    end
                end
                ST_PCHK: begin
                    phase_reg <= 1'b0;
                    if (is_touch) begin
                        last_raw_x_reg   <= (SWAP_AXES != 0) ? y_reg : x_reg;
                        last_raw_y_reg   <= (SWAP_AXES != 0) ? x_reg : y_reg;
                        touch_active_reg <= 1'b1;
                        press_time_reg   <= now_reg;
                    end else if (is_release) begin
                        touch_active_reg <= 1'b0;
                    end
                end
                ST_MUL1: begin
                    prod_reg <= prod_ext;
                end
                ST_MUL2: begin
                    acc_reg  <= prod_reg + coef_off_ext;
                    prod_reg <= prod_ext;
                end
                ST_ADD: begin
                    acc_reg <= acc_reg + prod_reg;
                end
                ST_DSTART: begin
                    negq_reg <= acc_reg[ACC_W-1] ^ divider_reg[COEF_W-1];
                end
                ST_CDIV: begin
                    // Store the truncated quotient, wrapped to 32 bits
                    if (div_rsp.done) begin
                        if (phase_reg) begin
                            last_cal_y_reg <= cal_q;
                        end else begin
                            last_cal_x_reg <= cal_q;
                        end
                        phase_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result register: hold until taken, reload on the same cycle it drains
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= touch_active_reg;
            m_tdata_reg <= {4'b0, last_cal_y_reg, last_cal_x_reg,
                            last_raw_y_reg, last_raw_x_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    a_ready_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_rsp.busy)
        else $error("ready while divider still running");

    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == ST_PDIV || state_reg == ST_CDIV))
        else $error("divider result arrived in an unexpected state");

    a_pen_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid_reg && (m_tuser_reg == touch_active_reg))
        else $error("pen_down does not match touch state");

    a_press_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PCHK && is_touch) |=> touch_active_reg
                                            && press_time_reg == $past(now_reg))
        else $error("press not recorded");

endmodule
